// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define BOS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("box overlap check failed");

// Clocked assertion that also holds across reset.
`define BOS_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("box overlap check failed");

`endif

// ===== rtl/bos_pkg.sv =====
// Shared types and constants of the box overlap score block.
package bos_pkg;

   localparam int COORD_BITS      = 24;
   localparam int SIZE_BITS       = 20;
   localparam int SCORE_FRAC_BITS = 16;
   localparam int SCORE_BITS      = SCORE_FRAC_BITS + 2;

   // Edges on doubled coordinates: 2*center -/+ extent
   localparam int EDGE_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
   // Every area (overlap, boxes, union, enclosing box)
   localparam int AREA_BITS = (2 * EDGE_BITS < 64) ? 2 * EDGE_BITS : 64;
   localparam int SHL_BITS  = (AREA_BITS < 64) ? AREA_BITS + 1 : 64;
   localparam int QUO_BITS  = SCORE_FRAC_BITS + 1;
   localparam int DIV_STAGES = SCORE_FRAC_BITS + 1;
   localparam int PROD_BITS = 2 * AREA_BITS;
   localparam int PSUM_BITS = (2 * AREA_BITS < 128) ? 2 * AREA_BITS + 1 : 128;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] OP_IOU  = 2'd0;
   localparam logic [1:0] OP_IOS  = 2'd1;
   localparam logic [1:0] OP_GIOU = 2'd2;

   localparam logic signed [SCORE_BITS-1:0] SCORE_ONE =
      SCORE_BITS'(1) <<< SCORE_FRAC_BITS;

   typedef struct packed {
      logic [1:0]                   op;
      logic signed [COORD_BITS-1:0] box_a_x;
      logic signed [COORD_BITS-1:0] box_a_y;
      logic [SIZE_BITS-1:0]         box_a_wid;
      logic [SIZE_BITS-1:0]         box_a_len;
      logic signed [COORD_BITS-1:0] box_b_x;
      logic signed [COORD_BITS-1:0] box_b_y;
      logic [SIZE_BITS-1:0]         box_b_wid;
      logic [SIZE_BITS-1:0]         box_b_len;
   } req_type;

   typedef struct packed {
      logic signed [SCORE_BITS-1:0] score;
      logic                         degenerate;
   } rsp_type;

   // Classified pair handed from front to back
   typedef struct packed {
      logic [1:0]           op;
      logic [AREA_BITS-1:0] inter;
      logic [AREA_BITS-1:0] uni;
      logic [AREA_BITS-1:0] small_area;
      logic [AREA_BITS-1:0] conv;
   } work_type;

endpackage

// ===== rtl/bos_front.sv =====
// Front end: accepts box pairs, forms edges and all areas in two stages.
module bos_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bos_pkg::req_type  req_data,
   output logic              wk_valid,
   input  logic              wk_ready,
   output bos_pkg::work_type wk_data
);
   import bos_pkg::*;

   logic adv;
   logic s1_valid_ff, s2_valid_ff;

   logic signed [EDGE_BITS-1:0] axc, ayc, bxc, byc, aws, als, bws, bls;
   logic signed [EDGE_BITS-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
   logic signed [EDGE_BITS-1:0] ix0, ix1, iy0, iy1, ex0, ex1, ey0, ey1;
   logic signed [EDGE_BITS:0]   ovx, ovy, dcx, dcy;
   logic [EDGE_BITS-1:0] ow_in, oh_in, cw_in, ch_in;
   logic [EDGE_BITS-1:0] ow_ff, oh_ff, cw_ff, ch_ff;
   logic [SIZE_BITS-1:0] aw_ff, al_ff, bw_ff, bl_ff;
   logic [1:0]           op1_ff, op2_ff;
   logic [AREA_BITS-1:0] inter_ff, area_a_ff, area_b_ff, conv_ff;

   assign adv       = !s2_valid_ff || wk_ready;
   assign req_ready = adv;

   always_comb begin
      axc = EDGE_BITS'(signed'({req_data.box_a_x, 1'b0}));
      ayc = EDGE_BITS'(signed'({req_data.box_a_y, 1'b0}));
      bxc = EDGE_BITS'(signed'({req_data.box_b_x, 1'b0}));
      byc = EDGE_BITS'(signed'({req_data.box_b_y, 1'b0}));
      aws = EDGE_BITS'(req_data.box_a_wid);
      als = EDGE_BITS'(req_data.box_a_len);
      bws = EDGE_BITS'(req_data.box_b_wid);
      bls = EDGE_BITS'(req_data.box_b_len);
      ax0 = axc - aws;  ax1 = axc + aws;
      ay0 = ayc - als;  ay1 = ayc + als;
      bx0 = bxc - bws;  bx1 = bxc + bws;
      by0 = byc - bls;  by1 = byc + bls;
      ix0 = (ax0 > bx0) ? ax0 : bx0;
      ix1 = (ax1 < bx1) ? ax1 : bx1;
      iy0 = (ay0 > by0) ? ay0 : by0;
      iy1 = (ay1 < by1) ? ay1 : by1;
      ex0 = (ax0 < bx0) ? ax0 : bx0;
      ex1 = (ax1 > bx1) ? ax1 : bx1;
      ey0 = (ay0 < by0) ? ay0 : by0;
      ey1 = (ay1 > by1) ? ay1 : by1;
      ovx = (EDGE_BITS+1)'(ix1) - (EDGE_BITS+1)'(ix0);
      ovy = (EDGE_BITS+1)'(iy1) - (EDGE_BITS+1)'(iy0);
      dcx = (EDGE_BITS+1)'(ex1) - (EDGE_BITS+1)'(ex0);
      dcy = (EDGE_BITS+1)'(ey1) - (EDGE_BITS+1)'(ey0);
      // clip a negative overlap to zero
      ow_in = ovx[EDGE_BITS] ? '0 : ovx[EDGE_BITS-1:0];
      oh_in = ovy[EDGE_BITS] ? '0 : ovy[EDGE_BITS-1:0];
      cw_in = dcx[EDGE_BITS-1:0];
      ch_in = dcy[EDGE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff    <= req_data.op;
         ow_ff     <= ow_in;
         oh_ff     <= oh_in;
         cw_ff     <= cw_in;
         ch_ff     <= ch_in;
         aw_ff     <= req_data.box_a_wid;
         al_ff     <= req_data.box_a_len;
         bw_ff     <= req_data.box_b_wid;
         bl_ff     <= req_data.box_b_len;
         op2_ff    <= op1_ff;
         inter_ff  <= AREA_BITS'(ow_ff * oh_ff);
         area_a_ff <= (AREA_BITS'(aw_ff) * AREA_BITS'(al_ff)) << 2;
         area_b_ff <= (AREA_BITS'(bw_ff) * AREA_BITS'(bl_ff)) << 2;
         conv_ff   <= AREA_BITS'(cw_ff * ch_ff);
      end
   end

   always_comb begin
      wk_valid           = s2_valid_ff;
      wk_data.op         = op2_ff;
      wk_data.inter      = inter_ff;
      wk_data.uni        = area_a_ff + area_b_ff - inter_ff;
      wk_data.small_area = (area_a_ff < area_b_ff) ? area_a_ff : area_b_ff;
      wk_data.conv       = conv_ff;
   end

endmodule

// ===== rtl/bos_queue.sv =====
// Short flop queue between the front and back ends.
module bos_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bos_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bos_pkg::work_type out_data
);
   import bos_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   work_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]    count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != (PTR_BITS+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

// ===== rtl/bos_div.sv =====
// Pipelined fractional divider: floor(2^F * num / den), one quotient bit per stage.
module bos_div (
   input  logic                                clock,
   input  logic                                en,
   input  logic [bos_pkg::AREA_BITS-1:0]       num,
   input  logic [bos_pkg::AREA_BITS-1:0]       den,
   output logic [bos_pkg::QUO_BITS-1:0]        quo,
   output logic [bos_pkg::AREA_BITS-1:0]       rem
);
   import bos_pkg::*;

   logic [AREA_BITS-1:0] rem_ff [DIV_STAGES];
   logic [AREA_BITS-1:0] rem_in [DIV_STAGES];
   logic [AREA_BITS-1:0] den_ff [DIV_STAGES];
   logic [QUO_BITS-1:0]  quo_ff [DIV_STAGES];
   logic [QUO_BITS-1:0]  quo_in [DIV_STAGES];
   logic                 first_ge;

   // integer bit first
   assign first_ge  = (num >= den);
   assign rem_in[0] = first_ge ? num - den : num;
   assign quo_in[0] = QUO_BITS'(first_ge);

   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
      logic [SHL_BITS-1:0] shl;
      logic                ge;
      assign shl       = SHL_BITS'({rem_ff[k-1], 1'b0});
      assign ge        = (shl >= SHL_BITS'(den_ff[k-1]));
      assign rem_in[k] = ge ? AREA_BITS'(shl - SHL_BITS'(den_ff[k-1])) : AREA_BITS'(shl);
      assign quo_in[k] = {quo_ff[k-1][QUO_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= den;
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
         for (int k = 1; k < DIV_STAGES; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];
   assign rem = rem_ff[DIV_STAGES-1];

endmodule

// ===== rtl/bos_mul.sv =====
// Two-stage wide multiplier built from four half-width partial products.
module bos_mul (
   input  logic                              clock,
   input  logic                              en,
   input  logic [bos_pkg::AREA_BITS-1:0]     a,
   input  logic [bos_pkg::AREA_BITS-1:0]     b,
   output logic [bos_pkg::PROD_BITS-1:0]     prod
);
   import bos_pkg::*;

   localparam int H = (AREA_BITS + 1) / 2;

   logic [H-1:0]         a_lo, a_hi, b_lo, b_hi;
   logic [2*H-1:0]       p00_ff, p01_ff, p10_ff, p11_ff;
   logic [PROD_BITS-1:0] prod_ff;

   assign a_lo = a[H-1:0];
   assign b_lo = b[H-1:0];
   assign a_hi = H'(a >> H);
   assign b_hi = H'(b >> H);

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= a_lo * b_lo;
         p01_ff  <= a_lo * b_hi;
         p10_ff  <= a_hi * b_lo;
         p11_ff  <= a_hi * b_hi;
         prod_ff <= PROD_BITS'(p00_ff)
                  + (PROD_BITS'(p01_ff) << H)
                  + (PROD_BITS'(p10_ff) << H)
                  + (PROD_BITS'(p11_ff) << (2 * H));
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/bos_back.sv =====
// Back end: divides, resolves the GIoU carry and registers the score.
module bos_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              wk_valid,
   output logic              wk_ready,
   input  bos_pkg::work_type wk_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bos_pkg::rsp_type  rsp_data
);
   import bos_pkg::*;

   localparam int FL_BITS = SCORE_FRAC_BITS + 3;

   typedef struct packed {
      logic [1:0]           op;
      logic                 degen;
      logic [AREA_BITS-1:0] uni;
      logic [AREA_BITS-1:0] conv;
   } dside_type;

   typedef struct packed {
      logic [1:0]          op;
      logic                degen;
      logic [QUO_BITS-1:0] q1;
      logic [QUO_BITS-1:0] q2;
      logic                r1z;
      logic                r2z;
   } mside_type;

   logic adv;
   logic degen_in;
   logic [AREA_BITS-1:0] den1;

   logic [DIV_STAGES-1:0] dv_ff;
   dside_type             dsb_ff [DIV_STAGES];
   dside_type             dlast;
   logic [QUO_BITS-1:0]   q1, q2;
   logic [AREA_BITS-1:0]  r1, r2;

   logic [1:0]           mv_ff;
   mside_type            msb_ff [2];
   logic [PROD_BITS-1:0] m1, m2, mp;

   logic                 sv_ff;
   mside_type            ssb_ff;
   logic [PSUM_BITS-1:0] sum_ff;
   logic [PROD_BITS-1:0] mp_ff;

   logic                 carry, exact;
   logic [FL_BITS-1:0]   fl, neg, gi;
   logic [SCORE_BITS-1:0] score_in;

   logic    out_valid_ff;
   rsp_type out_ff;

   assign adv      = !out_valid_ff || rsp_ready;
   assign wk_ready = adv;

   always_comb begin
      den1 = (wk_data.op == OP_IOS) ? wk_data.small_area : wk_data.uni;
      case (wk_data.op)
         OP_IOS:  degen_in = (wk_data.small_area == '0);
         OP_GIOU: degen_in = (wk_data.uni == '0) || (wk_data.conv == '0);
         default: degen_in = (wk_data.uni == '0);
      endcase
   end

   bos_div u_div_1 (.clock(clock), .en(adv), .num(wk_data.inter), .den(den1),
                    .quo(q1), .rem(r1));
   bos_div u_div_2 (.clock(clock), .en(adv), .num(wk_data.uni), .den(wk_data.conv),
                    .quo(q2), .rem(r2));

   assign dlast = dsb_ff[DIV_STAGES-1];

   bos_mul u_mul_1 (.clock(clock), .en(adv), .a(r1), .b(dlast.conv), .prod(m1));
   bos_mul u_mul_2 (.clock(clock), .en(adv), .a(r2), .b(dlast.uni), .prod(m2));
   bos_mul u_mul_p (.clock(clock), .en(adv), .a(dlast.uni), .b(dlast.conv), .prod(mp));

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff        <= '0;
         mv_ff        <= '0;
         sv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         dv_ff        <= {dv_ff[DIV_STAGES-2:0], wk_valid};
         mv_ff        <= {mv_ff[0], dv_ff[DIV_STAGES-1]};
         sv_ff        <= mv_ff[1];
         out_valid_ff <= sv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dsb_ff[0] <= '{op: wk_data.op, degen: degen_in, uni: wk_data.uni,
                        conv: wk_data.conv};
         for (int k = 1; k < DIV_STAGES; k++) begin
            dsb_ff[k] <= dsb_ff[k-1];
         end
         msb_ff[0] <= '{op: dlast.op, degen: dlast.degen, q1: q1, q2: q2,
                        r1z: (r1 == '0), r2z: (r2 == '0)};
         msb_ff[1] <= msb_ff[0];
         ssb_ff    <= msb_ff[1];
         sum_ff    <= PSUM_BITS'(m1) + PSUM_BITS'(m2);
         mp_ff     <= mp;
         out_ff    <= '{score: score_in, degenerate: ssb_ff.degen};
      end
   end

   // GIoU = I/U + U/C - 1; carry adds the lost fraction of the two remainders
   always_comb begin
      carry = (sum_ff >= PSUM_BITS'(mp_ff));
      exact = (ssb_ff.r1z && ssb_ff.r2z) || (sum_ff == PSUM_BITS'(mp_ff));
      fl    = FL_BITS'(ssb_ff.q1) + FL_BITS'(ssb_ff.q2) + FL_BITS'(carry);
      neg   = FL_BITS'(SCORE_ONE) - fl - FL_BITS'(!exact);
      if (fl >= FL_BITS'(SCORE_ONE)) gi = fl - FL_BITS'(SCORE_ONE);
      else gi = '0 - neg;
      if (ssb_ff.degen) score_in = '0;
      else if (ssb_ff.op == OP_GIOU) score_in = SCORE_BITS'(gi);
      else score_in = SCORE_BITS'(ssb_ff.q1);
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/box_overlap_score_top.sv =====
// Top level of the box overlap score block.
// Scores one pair of axis-aligned boxes per transaction as IoU, overlap over
// the smaller box area, or GIoU, in signed Q1.16 truncated toward zero; a zero
// divisor yields score 0 with degenerate set. One pair is accepted every cycle
// while the result side keeps up. From input to result a pair passes two front
// stages that form edges and areas, a four-entry queue, then the 17-stage
// restoring divider (one quotient bit per stage), two multiplier stages, one
// carry stage and the output register. The queue lets the front keep accepting
// while the result side stalls, until its four entries are full.
module box_overlap_score_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bos_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bos_pkg::rsp_type rsp_data
);
   import bos_pkg::*;

   logic     fq_valid, fq_ready, qb_valid, qb_ready;
   work_type fq_data, qb_data;

   bos_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .wk_valid(fq_valid), .wk_ready(fq_ready), .wk_data(fq_data)
   );

   bos_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
   );

   bos_back u_back (
      .clock(clock), .reset(reset),
      .wk_valid(qb_valid), .wk_ready(qb_ready), .wk_data(qb_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

// ===== rtl/bos_checker.sv =====
// Port-level checks of the box overlap score block, bound to the top level.
`include "assert_macros.svh"

module bos_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bos_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bos_pkg::rsp_type rsp_data
);
   import bos_pkg::*;

   `BOS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
   `BOS_ASSERT(a_degen_zero, clock, reset, (rsp_valid && rsp_data.degenerate) |-> (rsp_data.score == '0))
   `BOS_ASSERT(a_score_range, clock, reset, rsp_valid |-> ((rsp_data.score <= SCORE_ONE) && (rsp_data.score >= -SCORE_ONE)))
   `BOS_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind box_overlap_score_top bos_checker u_checker (.*);

// ===== tb/box_overlap_score_top_tb.sv =====
// Testbench for the box overlap score block: random and directed pairs against a predictor.
module box_overlap_score_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bos_pkg::*;

   class score_board;
      rsp_type pending[$];
      int errors = 0;

      // floor(2^F * a / b), a <= b
      function automatic void ratio_q(input logic [63:0] a, input logic [63:0] b,
                                      output logic [63:0] q, output logic [63:0] r);
         q = (a >= b) ? 64'd1 : 64'd0;
         r = q[0] ? a - b : a;
         for (int i = 0; i < SCORE_FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
               r = r - b;
               q[0] = 1'b1;
            end
         end
      endfunction

      function automatic rsp_type score_pair(input req_type t);
         longint ax, ay, bx, by, aw, al, bw, bl, ow, oh;
         longint ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
         logic [63:0] inter, area_a, area_b, uni, smaller, cw, ch, conv;
         logic [63:0] q1, q2, r1, r2, fl, one;
         logic [127:0] lhs, prod;
         longint sc;
         rsp_type o;
         sc = 0;
         o.degenerate = 1'b0;
         one = 64'd1 << SCORE_FRAC_BITS;
         ax = 2 * longint'(t.box_a_x); ay = 2 * longint'(t.box_a_y);
         bx = 2 * longint'(t.box_b_x); by = 2 * longint'(t.box_b_y);
         aw = longint'(t.box_a_wid); al = longint'(t.box_a_len);
         bw = longint'(t.box_b_wid); bl = longint'(t.box_b_len);
         ax0 = ax - aw; ax1 = ax + aw; ay0 = ay - al; ay1 = ay + al;
         bx0 = bx - bw; bx1 = bx + bw; by0 = by - bl; by1 = by + bl;
         ow = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
         oh = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
         if (ow < 0) ow = 0;
         if (oh < 0) oh = 0;
         inter = ow * oh;
         area_a = 4 * aw * al;
         area_b = 4 * bw * bl;
         uni = area_a + area_b - inter;
         if (t.op == OP_IOS) begin
            smaller = (area_a < area_b) ? area_a : area_b;
            if (smaller == 0) o.degenerate = 1'b1;
            else begin
               ratio_q(inter, smaller, q1, r1);
               sc = q1;
            end
         end else if (t.op == OP_GIOU) begin
            cw = ((ax1 > bx1) ? ax1 : bx1) - ((ax0 < bx0) ? ax0 : bx0);
            ch = ((ay1 > by1) ? ay1 : by1) - ((ay0 < by0) ? ay0 : by0);
            conv = cw * ch;
            if (uni == 0 || conv == 0) o.degenerate = 1'b1;
            else begin
               ratio_q(inter, uni, q1, r1);
               ratio_q(uni, conv, q2, r2);
               // compare leftover fractions r1/U + r2/C against one LSB
               lhs = 128'(r1) * 128'(conv) + 128'(r2) * 128'(uni);
               prod = 128'(uni) * 128'(conv);
               fl = q1 + q2 + ((lhs >= prod) ? 64'd1 : 64'd0);
               if (fl >= one) sc = fl - one;
               else sc = -longint'(one - fl -
                         (((r1 == 0 && r2 == 0) || lhs == prod) ? 64'd0 : 64'd1));
            end
         end else begin
            if (uni == 0) o.degenerate = 1'b1;
            else begin
               ratio_q(inter, uni, q1, r1);
               sc = q1;
            end
         end
         o.score = sc[SCORE_BITS-1:0];
         return o;
      endfunction

      function void note_pair(input req_type t);
         pending = {pending, score_pair(t)};
      endfunction

      function void check_score(input rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected transaction score=%0d", got.score);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.score !== want.score) begin
            $error("score expected %0d actual %0d", want.score, got.score);
            errors++;
         end
         if (got.degenerate !== want.degenerate) begin
            $error("degenerate expected %0d actual %0d", want.degenerate, got.degenerate);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset, req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   score_board board = new();
   bit calm = 0;
   int cycles = 0;

   box_overlap_score_top dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("box_overlap_score_top_tb failed");
         $finish;
      end
   end

   // result side: check and stall at random
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else begin
         if (rsp_valid && rsp_ready) board.check_score(rsp_data);
         rsp_ready <= calm || ($urandom_range(99) >= 20);
      end
   end

   function automatic logic [23:0] rand_coord(input int mode);
      case (mode)
         0: return 24'($urandom);
         default: return 24'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   function automatic logic [19:0] rand_size(input int mode);
      case ($urandom_range(9))
         0: return 20'd0;
         1: return 20'hFFFFF;
         2, 3: return 20'($urandom);
         default: return 20'($urandom_range(mode ? 1500 : 300));
      endcase
   endfunction

   task automatic send_pair(input req_type t);
      if (!calm) begin
         while ($urandom_range(99) < 20) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pair(t);
   endtask

   task automatic send_random;
      req_type t;
      int m;
      m = $urandom_range(3) != 0;
      t.op = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      t.box_a_x = rand_coord(m);
      t.box_a_y = rand_coord(m);
      t.box_a_wid = rand_size(m);
      t.box_a_len = rand_size(m);
      if ($urandom_range(3) == 0) begin
         t.box_b_x = rand_coord(m);
         t.box_b_y = rand_coord(m);
      end else begin
         t.box_b_x = t.box_a_x + 24'($signed($urandom_range(600)) - 300);
         t.box_b_y = t.box_a_y + 24'($signed($urandom_range(600)) - 300);
      end
      t.box_b_wid = rand_size(m);
      t.box_b_len = rand_size(m);
      send_pair(t);
   endtask

   function automatic req_type make_pair(input logic [1:0] op, input int ax, input int ay,
      input int aw, input int al, input int bx, input int by, input int bw, input int bl);
      req_type t;
      t.op = op;
      t.box_a_x = 24'(ax); t.box_a_y = 24'(ay);
      t.box_a_wid = 20'(aw); t.box_a_len = 20'(al);
      t.box_b_x = 24'(bx); t.box_b_y = 24'(by);
      t.box_b_wid = 20'(bw); t.box_b_len = 20'(bl);
      return t;
   endfunction

   initial begin
      int lim;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int op = 0; op < 4; op++) begin
         send_pair(make_pair(2'(op), 0, 0, 256, 256, 0, 0, 256, 256));
         send_pair(make_pair(2'(op), 0, 0, 256, 512, 100, -50, 300, 128));
         send_pair(make_pair(2'(op), 0, 0, 0, 0, 0, 0, 0, 0));
         send_pair(make_pair(2'(op), 0, 0, 0, 100, 5000, 0, 100, 0));
         send_pair(make_pair(2'(op), -8388608, -8388608, 1048575, 1048575,
                             8388607, 8388607, 1048575, 1048575));
         send_pair(make_pair(2'(op), 8388607, -8388608, 1048575, 0,
                             -8388608, 8388607, 0, 1));
      end
      send_pair(make_pair(OP_IOS, 0, 0, 100, 100, 1000, 1000, 0, 50));
      for (int i = 0; i < 1700; i++) begin
         if (i == 400) calm = 1;
         if (i == 700) calm = 0;
         if (i == 900) begin
            // hold off until the pipeline drains
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.pending.size() != 0) @(posedge clock);
         end
         send_random();
      end
      req_valid <= 1'b0;
      lim = 0;
      while (board.pending.size() != 0 && lim < 20000) begin
         @(posedge clock);
         lim++;
      end
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("box_overlap_score_top_tb passed");
      else
         $display("box_overlap_score_top_tb failed");
      $finish;
   end
endmodule
